// ===== hw/rtl/sup_pkg.sv =====
package sup_pkg;

  // Width of the ff-coded size field.
  localparam int unsigned SIZE_BITS  = 16;
  localparam int unsigned UUID_BYTES = 16;

  localparam logic [4:0] SEI_NAL_TYPE   = 5'd6;
  localparam logic [7:0] USER_DATA_TYPE = 8'h05;
  localparam logic [7:0] TRAILING_BYTE  = 8'h80;
  localparam logic [7:0] FF_BYTE        = 8'hff;
  localparam logic [7:0] EPB_BYTE       = 8'h03;

  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [SIZE_BITS:0]   size_sum_t;

  typedef enum logic [1:0] {
    KIND_UUID    = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_NAL_TYPE   = 3'd1,
    ERR_MSG_TYPE   = 3'd2,
    ERR_SIZE_SHORT = 3'd3,
    ERR_TRUNCATED  = 3'd4,
    ERR_SIZE_OVF   = 3'd5
  } err_t;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_START   = 5'b00010,
    PH_SIZE    = 5'b00100,
    PH_UUID    = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

endpackage

// ===== hw/rtl/sup_in_if.sv =====
interface sup_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hw/rtl/sup_out_if.sv =====
interface sup_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [15:0] byte_index;
  logic [7:0]  message_number;
  logic        end_of_message;
  logic [2:0]  error_code;

  modport source (
    output valid, output kind, output out_byte, output byte_index,
    output message_number, output end_of_message, output error_code,
    input ready
  );
  modport sink (
    input valid, input kind, input out_byte, input byte_index,
    input message_number, input end_of_message, input error_code,
    output ready
  );
endinterface

// ===== hw/rtl/sei_user_data_parser.sv =====
// SEI user-data-unregistered parser.
//
// in_ch carries the raw bytes of one NAL unit, header byte first, with
// last_byte set on the final beat. The header must be NAL type 6; after it,
// emulation-prevention 0x03 bytes following two zeros are dropped and SEI
// messages (type 5 only, size at least 16) are parsed up to the 0x80 byte.
// out_ch carries one beat per uuid or payload byte, then a single complete
// or error beat; bytes after that are swallowed until the end of the unit.
// Output: each result is registered and appears on out_ch in the cycle after its input beat.
// Throughput: one input beat per cycle while out_ch is not stalled; the whole parse step for a byte is
// a small state update between the input handshake and the output register.
// Stall: the output register holds its beat while out_ch.ready is low; the
// input is still taken whenever that register is empty or being drained
// in the same cycle, so a stalled receiver stalls the sender one-for-one.
// Reset: synchronous, active low; the parser waits for a header byte and
// out_ch is empty. State also returns to this point after every last beat.
module sei_user_data_parser
  import sup_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  sup_in_if.sink     in_ch,
  sup_out_if.source  out_ch
);

  // Parse state.
  phase_t      phase_r,     phase_nxt;
  logic [1:0]  zero_run_r,  zero_run_nxt;
  size_sum_t   field_sum_r, field_sum_nxt;
  size_t       bytes_left_r, bytes_left_nxt;
  size_t       field_pos_r, field_pos_nxt;
  logic [7:0]  msg_count_r, msg_count_nxt;
  logic        halted_r,    halted_nxt;

  // Output register.
  logic        out_valid_r;
  kind_t       kind_r,  kind_nxt;
  logic [7:0]  byte_r,  byte_nxt;
  logic [15:0] index_r, index_nxt;
  logic [7:0]  msg_r,   msg_nxt;
  logic        eom_r,   eom_nxt;
  err_t        err_r,   err_nxt;
  logic        have;

  logic        in_fire;
  logic [7:0]  b;
  logic        last;
  size_sum_t   sum_add;
  logic        clear_unit;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign last        = in_ch.last_byte;
  assign sum_add     = field_sum_r + size_sum_t'(b);

  always_comb begin
    phase_nxt      = phase_r;
    zero_run_nxt   = zero_run_r;
    field_sum_nxt  = field_sum_r;
    bytes_left_nxt = bytes_left_r;
    field_pos_nxt  = field_pos_r;
    msg_count_nxt  = msg_count_r;
    halted_nxt     = halted_r;
    have           = 1'b0;
    kind_nxt       = KIND_UUID;
    byte_nxt       = '0;
    index_nxt      = '0;
    msg_nxt        = msg_count_r;
    eom_nxt        = 1'b0;
    err_nxt        = ERR_NONE;
    clear_unit     = 1'b0;

    if (halted_r) begin
      // Swallow the rest of the unit silently.
      clear_unit = last;
    end else begin
      if (phase_r == PH_HEADER) begin
        zero_run_nxt = '0;
        if (b[4:0] != SEI_NAL_TYPE) begin
          have     = 1'b1;
          kind_nxt = KIND_ERROR;
          err_nxt  = ERR_NAL_TYPE;
        end else begin
          phase_nxt = PH_START;
        end
      end else if (zero_run_r == 2'd2 && b == EPB_BYTE) begin
        // Drop the emulation-prevention byte and restart the zero count.
        zero_run_nxt = '0;
      end else begin
        if (b == 8'h00) begin
          zero_run_nxt = (zero_run_r == 2'd2) ? 2'd2 : zero_run_r + 2'd1;
        end else begin
          zero_run_nxt = '0;
        end
        unique case (phase_r)
          PH_START: begin
            if (b == TRAILING_BYTE) begin
              have     = 1'b1;
              kind_nxt = KIND_DONE;
            end else if (b != USER_DATA_TYPE) begin
              have     = 1'b1;
              kind_nxt = KIND_ERROR;
              err_nxt  = ERR_MSG_TYPE;
            end else begin
              field_sum_nxt = '0;
              phase_nxt     = PH_SIZE;
            end
          end
          PH_SIZE: begin
            field_sum_nxt = sum_add;
            if (sum_add[SIZE_BITS]) begin
              have     = 1'b1;
              kind_nxt = KIND_ERROR;
              err_nxt  = ERR_SIZE_OVF;
            end else if (b != FF_BYTE) begin
              if (sum_add < size_sum_t'(UUID_BYTES)) begin
                have     = 1'b1;
                kind_nxt = KIND_ERROR;
                err_nxt  = ERR_SIZE_SHORT;
              end else begin
                bytes_left_nxt = SIZE_BITS'(sum_add - size_sum_t'(UUID_BYTES));
                field_pos_nxt  = '0;
                phase_nxt      = PH_UUID;
              end
            end
          end
          PH_UUID: begin
            have      = 1'b1;
            kind_nxt  = KIND_UUID;
            byte_nxt  = b;
            index_nxt = 16'(field_pos_r);
            eom_nxt   = (field_pos_r == size_t'(UUID_BYTES - 1)) &&
                        (bytes_left_r == '0);
            if (field_pos_r == size_t'(UUID_BYTES - 1)) begin
              field_pos_nxt = '0;
              if (bytes_left_r == '0) begin
                msg_count_nxt = msg_count_r + 8'd1;
                phase_nxt     = PH_START;
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end else begin
              field_pos_nxt = field_pos_r + size_t'(1);
            end
          end
          PH_PAYLOAD: begin
            have      = 1'b1;
            kind_nxt  = KIND_PAYLOAD;
            byte_nxt  = b;
            index_nxt = 16'(field_pos_r);
            eom_nxt   = (bytes_left_r <= size_t'(1));
            field_pos_nxt = field_pos_r + size_t'(1);
            if (bytes_left_r <= size_t'(1)) begin
              bytes_left_nxt = '0;
              field_pos_nxt  = '0;
              msg_count_nxt  = msg_count_r + 8'd1;
              phase_nxt      = PH_START;
            end else begin
              bytes_left_nxt = bytes_left_r - size_t'(1);
            end
          end
          default: begin
            phase_nxt = PH_HEADER;
          end
        endcase
      end

      if (have && (kind_nxt == KIND_DONE || kind_nxt == KIND_ERROR)) begin
        msg_nxt = msg_count_nxt;
        if (last) begin
          clear_unit = 1'b1;
        end else begin
          halted_nxt = 1'b1;
        end
      end else if (last) begin
        // Unit ended before a complete or error beat: report truncation instead of any byte.
        have       = 1'b1;
        kind_nxt   = KIND_ERROR;
        err_nxt    = ERR_TRUNCATED;
        byte_nxt   = '0;
        index_nxt  = '0;
        eom_nxt    = 1'b0;
        msg_nxt    = msg_count_nxt;
        clear_unit = 1'b1;
      end
    end

    if (clear_unit) begin
      phase_nxt      = PH_HEADER;
      zero_run_nxt   = '0;
      field_sum_nxt  = '0;
      bytes_left_nxt = '0;
      field_pos_nxt  = '0;
      msg_count_nxt  = '0;
      halted_nxt     = 1'b0;
    end
  end

  // Advance parse state on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      zero_run_r   <= '0;
      field_sum_r  <= '0;
      bytes_left_r <= '0;
      field_pos_r  <= '0;
      msg_count_r  <= '0;
      halted_r     <= 1'b0;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      zero_run_r   <= zero_run_nxt;
      field_sum_r  <= field_sum_nxt;
      bytes_left_r <= bytes_left_nxt;
      field_pos_r  <= field_pos_nxt;
      msg_count_r  <= msg_count_nxt;
      halted_r     <= halted_nxt;
    end
  end

  // Load the output register on accept; drop the beat once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= have;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r  <= kind_nxt;
      byte_r  <= byte_nxt;
      index_r <= index_nxt;
      msg_r   <= msg_nxt;
      eom_r   <= eom_nxt;
      err_r   <= err_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = kind_r;
  assign out_ch.out_byte       = byte_r;
  assign out_ch.byte_index     = index_r;
  assign out_ch.message_number = msg_r;
  assign out_ch.end_of_message = eom_r;
  assign out_ch.error_code     = err_r;

  // A swallowed beat never produces a result.
  a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && halted_r |=> !out_valid_r)
    else $error("result produced while halted");

  // The end of a unit always brings the parser back to a fresh header.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.last_byte |=>
      phase_r == PH_HEADER && !halted_r && msg_count_r == '0)
    else $error("state not cleared after last beat");

  a_uuid_pos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_UUID |-> field_pos_r < size_t'(UUID_BYTES))
    else $error("uuid position out of range");

  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> bytes_left_r != '0)
    else $error("payload phase with nothing left");

  // An overflowing size halts the parser, so only a live size is bounded.
  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SIZE && !halted_r |-> !field_sum_r[SIZE_BITS])
    else $error("running size beyond limit");

endmodule

// ===== sim/tb_sei_user_data_parser.sv =====
module tb_sei_user_data_parser
  import sup_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Largest size that the ff-coded size field may reach.
  localparam size_sum_t SIZE_MAX = size_sum_t'((1 << SIZE_BITS) - 1);
  // Cycles without any beat on either channel before the run is abandoned.
  localparam int unsigned STALL_LIMIT = 1000;
  // Random beats wanted, and the point after which all idling stops.
  localparam int unsigned RANDOM_BEATS = 850;
  localparam int unsigned CALM_AFTER   = 700;

  // One result beat as the parser should present it.
  typedef struct {
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] index;
    logic [7:0]  msg;
    logic        eom;
    err_t        err;
  } parse_beat_t;

  // Mirrors the parser state byte by byte. It holds the result beats that
  // are owed and compares each delivered beat with the oldest of them.
  class parse_outcome_log;
    phase_t      phase;
    logic [1:0]  zero_run;
    size_sum_t   field_sum;
    size_t       bytes_left;
    logic [15:0] field_pos;
    logic [7:0]  msg_count;
    bit          halted;
    parse_beat_t pending_beats[$];
    int unsigned fail_count;

    function new();
      fail_count = 0;
      restart();
    endfunction

    function void restart();
      phase     = PH_HEADER;
      zero_run  = '0;
      field_sum = '0;
      bytes_left = '0;
      field_pos = '0;
      msg_count = '0;
      halted    = 1'b0;
    endfunction

    function int unsigned owed();
      return pending_beats.size();
    endfunction

    function void take_nal_byte(logic [7:0] b, logic last);
      parse_beat_t r;
      bit have;
      have    = 1'b0;
      r.kind  = KIND_UUID;
      r.data  = '0;
      r.index = '0;
      r.msg   = msg_count;
      r.eom   = 1'b0;
      r.err   = ERR_NONE;

      // Swallow everything up to the end of a unit that has already reported.
      if (halted) begin
        if (last) restart();
        return;
      end

      if (phase == PH_HEADER) begin
        zero_run = '0;
        if (b[4:0] != SEI_NAL_TYPE) begin
          have  = 1'b1;
          r.kind = KIND_ERROR;
          r.err  = ERR_NAL_TYPE;
        end else begin
          phase = PH_START;
        end
      end else if (zero_run == 2'd2 && b == EPB_BYTE) begin
        // Emulation-prevention byte: drop it and restart the zero count.
        zero_run = '0;
      end else begin
        if (b == 8'h00) zero_run = (zero_run < 2'd2) ? zero_run + 2'd1 : 2'd2;
        else zero_run = '0;
        case (phase)
          PH_START: begin
            if (b == TRAILING_BYTE) begin
              have   = 1'b1;
              r.kind = KIND_DONE;
            end else if (b != USER_DATA_TYPE) begin
              have   = 1'b1;
              r.kind = KIND_ERROR;
              r.err  = ERR_MSG_TYPE;
            end else begin
              field_sum = '0;
              phase     = PH_SIZE;
            end
          end
          PH_SIZE: begin
            field_sum = field_sum + size_sum_t'(b);
            if (field_sum > SIZE_MAX) begin
              have   = 1'b1;
              r.kind = KIND_ERROR;
              r.err  = ERR_SIZE_OVF;
            end else if (b != FF_BYTE) begin
              if (field_sum < UUID_BYTES) begin
                have   = 1'b1;
                r.kind = KIND_ERROR;
                r.err  = ERR_SIZE_SHORT;
              end else begin
                bytes_left = size_t'(field_sum - UUID_BYTES);
                field_pos  = '0;
                phase      = PH_UUID;
              end
            end
          end
          PH_UUID: begin
            have    = 1'b1;
            r.kind  = KIND_UUID;
            r.data  = b;
            r.index = field_pos;
            r.eom   = (field_pos == UUID_BYTES - 1) && (bytes_left == '0);
            field_pos = field_pos + 16'd1;
            if (field_pos >= UUID_BYTES) begin
              field_pos = '0;
              if (bytes_left == '0) begin
                msg_count = msg_count + 8'd1;
                phase     = PH_START;
              end else begin
                phase = PH_PAYLOAD;
              end
            end
          end
          default: begin
            have    = 1'b1;
            r.kind  = KIND_PAYLOAD;
            r.data  = b;
            r.index = field_pos;
            r.eom   = (bytes_left <= 1);
            field_pos = field_pos + 16'd1;
            if (bytes_left != '0) bytes_left = bytes_left - 1'b1;
            if (bytes_left == '0) begin
              field_pos = '0;
              msg_count = msg_count + 8'd1;
              phase     = PH_START;
            end
          end
        endcase
      end

      if (have && (r.kind == KIND_DONE || r.kind == KIND_ERROR)) begin
        r.msg = msg_count;
        if (last) restart();
        else halted = 1'b1;
      end else if (last) begin
        // Unit ended before it could finish: report truncation instead.
        have    = 1'b1;
        r.kind  = KIND_ERROR;
        r.data  = '0;
        r.index = '0;
        r.eom   = 1'b0;
        r.err   = ERR_TRUNCATED;
        r.msg   = msg_count;
        restart();
      end

      if (have) pending_beats.insert(pending_beats.size(), r);
    endfunction

    function void match_result(parse_beat_t got);
      parse_beat_t want;
      bit bad;
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing owed: kind %0d out_byte %0h", got.kind, got.data);
        fail_count++;
        return;
      end
      want = pending_beats.pop_front();
      bad  = 1'b0;
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
        bad = 1'b1;
      end
      if (got.data !== want.data) begin
        $error("out_byte: expected %0h, actual %0h", want.data, got.data);
        bad = 1'b1;
      end
      if (got.index !== want.index) begin
        $error("byte_index: expected %0d, actual %0d", want.index, got.index);
        bad = 1'b1;
      end
      if (got.msg !== want.msg) begin
        $error("message_number: expected %0d, actual %0d", want.msg, got.msg);
        bad = 1'b1;
      end
      if (got.eom !== want.eom) begin
        $error("end_of_message: expected %0b, actual %0b", want.eom, got.eom);
        bad = 1'b1;
      end
      if (got.err !== want.err) begin
        $error("error_code: expected %0d, actual %0d", want.err, got.err);
        bad = 1'b1;
      end
      if (bad) fail_count++;
    endfunction
  endclass

  logic clk;
  logic rst_n;

  sup_in_if  in_ch ();
  sup_out_if out_ch ();

  sei_user_data_parser DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  parse_outcome_log outcome;

  // Idling odds in percent, per beat, for the sender and the receiver.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // Book-keeping for the unit being sent.
  int  cut_at;        // beat number forced to carry last_byte, -1 for none
  int  emitted;       // beats sent in this unit so far
  bit  unit_closed;   // last_byte already sent
  int  esc_zeros;     // zero run seen by the escaping encoder
  bit  counting;      // whether beats count towards the random total
  int unsigned random_beats;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: now and then hold ready low for a burst of random length.
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (recv_idle_pct != 0 && $urandom_range(1, 100) <= recv_idle_pct) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Both channels are sampled at the same edge, inputs first, so a result
  // given in the same cycle as its input would still find its expectation in place.
  always @(posedge clk) begin
    parse_beat_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) outcome.take_nal_byte(in_ch.data_byte, in_ch.last_byte);
      if (out_ch.valid && out_ch.ready) begin
        got.kind  = kind_t'(out_ch.kind);
        got.data  = out_ch.out_byte;
        got.index = out_ch.byte_index;
        got.msg   = out_ch.message_number;
        got.eom   = out_ch.end_of_message;
        got.err   = err_t'(out_ch.error_code);
        outcome.match_result(got);
      end
    end
  end

  // Watchdog: abandon the run after too long without any beat moving.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one beat, optionally after a random gap, and hold it until taken.
  task automatic send_beat(input logic [7:0] b, input logic l);
    int gap;
    @(negedge clk);
    if (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      gap = $urandom_range(1, 17);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic begin_unit();
    cut_at      = -1;
    emitted     = 0;
    unit_closed = 1'b0;
    esc_zeros   = 0;
  endtask

  // Send a raw byte; force last_byte at the cut point, drop bytes past the end.
  task automatic put_byte(input logic [7:0] b, input logic l);
    if (unit_closed) return;
    if (cut_at >= 0 && emitted >= cut_at) l = 1'b1;
    send_beat(b, l);
    emitted++;
    if (counting) random_beats++;
    if (l) unit_closed = 1'b1;
  endtask

  // Send a payload byte the way an encoder would, inserting 0x03 after two
  // zeros whenever the next byte could otherwise mimic a start code.
  task automatic esc_byte(input logic [7:0] b, input logic l);
    if (esc_zeros == 2 && b <= EPB_BYTE) begin
      put_byte(EPB_BYTE, 1'b0);
      esc_zeros = 0;
    end
    put_byte(b, l);
    if (b == 8'h00) esc_zeros = (esc_zeros < 2) ? esc_zeros + 1 : 2;
    else esc_zeros = 0;
  endtask

  // Content bytes lean towards zeros, 0x01 to 0x03, 0x80 and 0xff to stir the escaping.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2: return 8'h00;
      3:       return 8'($urandom_range(1, 3));
      4:       return FF_BYTE;
      5:       return TRAILING_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int unsigned pick_pct();
    int r;
    r = $urandom_range(0, 3);
    case (r)
      0:       return 0;
      1:       return 5;
      2:       return 15;
      default: return 40;
    endcase
  endfunction

  // Stop feeding and wait until every owed result beat has been delivered.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (outcome.owed() != 0) @(posedge clk);
  endtask

  // One NAL unit. Mostly well-formed SEI units with random content; some
  // carry a broken message, get cut short, or are plain noise. The giant
  // unit carries one message whose size needs an ff byte, ovf
  // one whose size runs past the field.
  task automatic gen_unit(input bit giant, input bit ovf);
    int nmsg;
    int pick;
    int size;
    int coded;
    logic [7:0] b;
    begin_unit();

    if (!giant && !ovf && $urandom_range(0, 9) == 0) begin
      // Noise: any header, a handful of raw bytes, no escaping.
      nmsg = $urandom_range(0, 9);
      if ($urandom_range(0, 1) != 0) b = 8'($urandom_range(0, 255));
      else b = {3'($urandom), SEI_NAL_TYPE};
      put_byte(b, nmsg == 0);
      for (int i = 1; i <= nmsg; i++) put_byte(pick_byte(), i == nmsg);
      return;
    end

    if (!giant && !ovf && $urandom_range(0, 7) == 0) cut_at = $urandom_range(1, 60);
    put_byte({3'($urandom), SEI_NAL_TYPE}, 1'b0);
    esc_zeros = 0;
    nmsg = (giant || ovf) ? 1 : $urandom_range(0, 3);

    for (int m = 0; m < nmsg; m++) begin
      pick = (giant || ovf) ? 15 : $urandom_range(0, 15);
      if (ovf) begin
        // 257 ff bytes reach the limit exactly; any further non-zero overflows.
        esc_byte(USER_DATA_TYPE, 1'b0);
        repeat (257) esc_byte(FF_BYTE, 1'b0);
        esc_byte(8'($urandom_range(1, 255)), 1'b0);
      end else if (pick == 0) begin
        esc_byte(FF_BYTE, 1'b0);
      end else if (pick == 1) begin
        do b = 8'($urandom_range(0, 255));
        while (b == USER_DATA_TYPE || b == TRAILING_BYTE);
        esc_byte(b, 1'b0);
      end else begin
        esc_byte(USER_DATA_TYPE, 1'b0);
        if (pick == 2) begin
          esc_byte(8'($urandom_range(0, UUID_BYTES - 1)), 1'b0);
        end else begin
          if (giant) size = $urandom_range(255, 320);
          else if ($urandom_range(0, 3) == 0) size = UUID_BYTES;
          else size = $urandom_range(UUID_BYTES, 48);
          coded = size;
          while (coded >= 255) begin
            esc_byte(FF_BYTE, 1'b0);
            coded -= 255;
          end
          esc_byte(8'(coded), 1'b0);
          repeat (size) esc_byte(pick_byte(), 1'b0);
          continue;
        end
      end
      // Broken message: the parser has stopped, trail some junk to the end.
      repeat ($urandom_range(0, 3)) put_byte(pick_byte(), 1'b0);
      put_byte(pick_byte(), 1'b1);
      return;
    end

    if ($urandom_range(0, 4) == 0) begin
      // Bytes after the trailing byte are ignored up to the last one.
      esc_byte(TRAILING_BYTE, 1'b0);
      nmsg = $urandom_range(1, 3);
      for (int i = 1; i <= nmsg; i++) put_byte(pick_byte(), i == nmsg);
    end else begin
      esc_byte(TRAILING_BYTE, 1'b1);
    end
  endtask

  initial begin
    int unit_no;
    outcome         = new();
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    counting        = 1'b0;
    random_beats    = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed units, light idling on both sides.
    send_idle_pct = 20;
    recv_idle_pct = 20;
    // Header that is not SEI, alone in its unit.
    begin_unit(); put_byte(8'h65, 1'b1);
    // Header only: truncated.
    begin_unit(); put_byte(8'h06, 1'b1);
    // Type byte of 0xff, then bytes swallowed to the end.
    begin_unit(); put_byte(8'h66, 1'b0); put_byte(FF_BYTE, 1'b0);
    put_byte(8'h00, 1'b0); put_byte(8'h12, 1'b1);
    // Forbidden bit set, size under sixteen.
    begin_unit(); put_byte(8'h86, 1'b0); put_byte(USER_DATA_TYPE, 1'b0);
    put_byte(8'h0f, 1'b0); put_byte(8'h00, 1'b1);
    // Empty SEI: trailing byte straight away, then one ignored byte.
    begin_unit(); put_byte(8'h06, 1'b0); put_byte(TRAILING_BYTE, 1'b0);
    put_byte(FF_BYTE, 1'b1);
    // Unit ends on a dropped emulation-prevention byte.
    begin_unit(); put_byte(8'h06, 1'b0); put_byte(USER_DATA_TYPE, 1'b0);
    put_byte(8'h10, 1'b0); put_byte(8'h00, 1'b0); put_byte(8'h00, 1'b0);
    put_byte(EPB_BYTE, 1'b1);
    // Bad header without last: the next byte, which ends the unit, is swallowed.
    begin_unit(); put_byte(8'hff, 1'b0); put_byte(8'h06, 1'b1);

    // Random units until enough beats have gone by.
    counting = 1'b1;
    unit_no  = 0;
    while (random_beats < RANDOM_BEATS) begin
      if (random_beats > CALM_AFTER) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = pick_pct();
        recv_idle_pct = pick_pct();
      end
      if (unit_no == 3) begin
        // Long message: keep idling thin so the run stays short.
        send_idle_pct = 2;
        recv_idle_pct = 2;
        gen_unit(1'b1, 1'b0);
      end else if (unit_no == 6 || unit_no == 20) begin
        gen_unit(1'b0, 1'b1);
      end else begin
        gen_unit(1'b0, 1'b0);
      end
      // Hold the sender once until the parser has caught up completely.
      if (unit_no == 10) wait_drained();
      unit_no++;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (outcome.owed() != 0) $error("%0d result beats never arrived", outcome.owed());
    if (outcome.fail_count == 0 && outcome.owed() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
